// ----- sv/bmt_pkg.sv -----
`timescale 1ns / 1ps

package bmt_pkg;

  // default and ceiling for the number of cordic iterations
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;

  // angles in 1/65536 degree
  localparam logic signed [26:0] DEG90  = 27'sd5898240;
  localparam logic signed [26:0] DEG180 = 27'sd11796480;
  localparam logic signed [26:0] DEG360 = 27'sd23592960;

  localparam logic signed [33:0] CORDIC_K   = 34'sd652032874;
  localparam logic [29:0]        RAD2DEG_Q16 = 30'd961263669;
  localparam logic signed [15:0] STEER_MAX  = 16'sd21760;
  localparam logic [27:0]        VEL_MAX    = 28'd8388608;
  localparam logic [31:0]        YAW_MAX    = 32'd8388607;

  // quotient bits of the yaw divider
  localparam int DIV_BITS = 32;

  // register indexes on the configuration port
  localparam logic CFG_AXLE_RATIO = 1'b0;
  localparam logic CFG_WHEELBASE  = 1'b1;

  // round(atan(2^-i) * 65536) in degrees
  localparam logic [21:0] ATAN_TAB [ATAN_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117302,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
    22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
    22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
  };

  // everything one pipeline stage carries
  typedef struct packed {
    logic signed [16:0] hd;
    logic signed [15:0] spd;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [26:0] z;
    logic               neg;
    logic               yneg;
    logic signed [50:0] prod;
    logic [49:0]        mp;
    logic [31:0]        mm;
    logic [61:0]        np;
    logic [31:0]        dd;
    logic [16:0]        rem;
    logic [31:0]        quot;
    logic [49:0]        px;
    logic [49:0]        py;
    logic               xneg;
    logic               vyneg;
    logic signed [24:0] vx;
    logic signed [24:0] vy;
  } item_t;

  typedef struct packed {
    logic               sat;
    logic signed [23:0] yaw;
    logic signed [24:0] vy;
    logic signed [24:0] vx;
  } res_t;

endpackage

// ----- sv/bicycle_model_twist.sv -----
`timescale 1ns / 1ps

// Kinematic bicycle model twist: for each (heading, steering, speed) transaction the block
// returns the planar velocity speed*(cos, sin)(heading + beta), beta = atan(axle_ratio *
// tan(steering)), and the yaw rate speed*sin(steering)/wheelbase in 1/256 degree per second,
// clipped with yaw_saturated set. It takes one transaction every clock cycle while no
// result is parked in the skid register. The pipeline holds three cordic chains of N
// stages each, N = min(CORDIC_STAGES, 24), and the 32 stage restoring yaw path divider.
// A stalled output holds one result in a skid register while the next is accepted.
// Configuration must only be written while the pipeline is empty.
module bicycle_model_twist #(
  parameter int CORDIC_STAGES = bmt_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // heading[16:0], steering[32:17], speed[48:33]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // vel_x[24:0], vel_y[49:25], turn_rate[73:50]
  output logic        m_axis_tuser,   // yaw_saturated
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int NS   = (CORDIC_STAGES > bmt_pkg::ATAN_LEN) ? bmt_pkg::ATAN_LEN : CORDIC_STAGES;
  localparam int C1   = 1;               // first rotation: steering
  localparam int P1   = C1 + NS;         // products of sin(steer)
  localparam int P2   = P1 + 1;          // truncation, yaw magnitude
  localparam int P2B  = P2 + 1;          // yaw magnitude times rad to deg
  localparam int P2C  = P2B + 1;         // dividend
  localparam int C2   = P2C + 1;         // vectoring: slip angle
  localparam int P3   = C2 + NS;         // wrap and fold
  localparam int C3   = P3 + 1;          // second rotation: course
  localparam int P4   = C3 + NS;         // velocity products
  localparam int P5   = P4 + 1;          // velocity rounding
  localparam int DV   = P5 + 1;          // divider steps
  localparam int P6   = DV + bmt_pkg::DIV_BITS;
  localparam int NST  = P6;

  logic [15:0] axle_ratio_r;
  logic [15:0] wheelbase_r;
  logic [15:0] wb;

  bmt_pkg::item_t st_r   [NST];
  bmt_pkg::item_t st_nxt [NST];
  logic [NST-1:0] vld_r;

  bmt_pkg::res_t  skid_r;
  bmt_pkg::res_t  last_res;
  logic           skid_v_r;
  logic           en;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axle_ratio_r <= 16'd32768;
      wheelbase_r  <= 16'd300;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bmt_pkg::CFG_AXLE_RATIO: axle_ratio_r <= cfg_data;
        bmt_pkg::CFG_WHEELBASE:  wheelbase_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign wb = (wheelbase_r == 16'd0) ? 16'd1 : wheelbase_r;

  // pipeline advances unless a result is parked in the skid register
  assign en            = !skid_v_r;
  assign s_axis_tready = en;

  // input capture with steering clamp
  always_comb begin
    logic signed [15:0] steer;
    st_nxt[0] = '0;
    steer = $signed(s_axis_tdata[32:17]);
    if (steer > bmt_pkg::STEER_MAX)       steer = bmt_pkg::STEER_MAX;
    else if (steer < -bmt_pkg::STEER_MAX) steer = -bmt_pkg::STEER_MAX;
    st_nxt[0].hd  = $signed(s_axis_tdata[16:0]);
    st_nxt[0].spd = $signed(s_axis_tdata[48:33]);
    st_nxt[0].x   = bmt_pkg::CORDIC_K;
    st_nxt[0].y   = '0;
    st_nxt[0].z   = {{3{steer[15]}}, steer, 8'd0};
  end

  genvar k;
  generate
    for (k = 1; k < NST; k++) begin : g_stage
      if ((k >= C1 && k < C1 + NS) || (k >= C3 && k < C3 + NS)) begin : g_rot
        localparam int I = (k >= C3) ? k - C3 : k - C1;
        // rotation step toward zero residual angle
        always_comb begin
          logic signed [26:0] a;
          st_nxt[k] = st_r[k-1];
          a = $signed({5'd0, bmt_pkg::ATAN_TAB[I]});
          if (!st_r[k-1].z[26]) begin
            st_nxt[k].x = st_r[k-1].x - (st_r[k-1].y >>> I);
            st_nxt[k].y = st_r[k-1].y + (st_r[k-1].x >>> I);
            st_nxt[k].z = st_r[k-1].z - a;
          end else begin
            st_nxt[k].x = st_r[k-1].x + (st_r[k-1].y >>> I);
            st_nxt[k].y = st_r[k-1].y - (st_r[k-1].x >>> I);
            st_nxt[k].z = st_r[k-1].z + a;
          end
        end
      end else if (k >= C2 && k < C2 + NS) begin : g_vec
        localparam int I = k - C2;
        // vectoring step driving y to zero
        always_comb begin
          logic signed [26:0] a;
          st_nxt[k] = st_r[k-1];
          a = $signed({5'd0, bmt_pkg::ATAN_TAB[I]});
          if (!st_r[k-1].y[33]) begin
            st_nxt[k].x = st_r[k-1].x + (st_r[k-1].y >>> I);
            st_nxt[k].y = st_r[k-1].y - (st_r[k-1].x >>> I);
            st_nxt[k].z = st_r[k-1].z + a;
          end else begin
            st_nxt[k].x = st_r[k-1].x - (st_r[k-1].y >>> I);
            st_nxt[k].y = st_r[k-1].y + (st_r[k-1].x >>> I);
            st_nxt[k].z = st_r[k-1].z - a;
          end
        end
      end else if (k == P1) begin : g_p1
        // sin(steer) times axle ratio, and |speed| * |sin(steer)|
        always_comb begin
          logic [33:0] ay;
          logic [16:0] as;
          st_nxt[k] = st_r[k-1];
          ay = st_r[k-1].y[33] ? 34'(-st_r[k-1].y) : 34'(st_r[k-1].y);
          as = st_r[k-1].spd[15] ? 17'(-{st_r[k-1].spd[15], st_r[k-1].spd})
                                 : {1'b0, st_r[k-1].spd};
          st_nxt[k].prod = 51'(st_r[k-1].y * $signed({1'b0, axle_ratio_r}));
          st_nxt[k].mp   = 50'(as * ay[32:0]);
          st_nxt[k].yneg = st_r[k-1].spd[15] != st_r[k-1].y[33];
        end
      end else if (k == P2) begin : g_p2
        // divide by 2^16 truncating toward zero; round yaw magnitude to q16
        always_comb begin
          logic signed [50:0] t;
          st_nxt[k] = st_r[k-1];
          t = st_r[k-1].prod[50] ? (st_r[k-1].prod + 51'sd65535) : st_r[k-1].prod;
          st_nxt[k].y  = 34'(t >>> 16);
          st_nxt[k].z  = '0;
          st_nxt[k].mm = 32'((st_r[k-1].mp + 50'd8192) >> 14);
        end
      end else if (k == P2B) begin : g_p2b
        always_comb begin
          st_nxt[k]    = st_r[k-1];
          st_nxt[k].np = 62'(st_r[k-1].mm * bmt_pkg::RAD2DEG_Q16);
        end
      end else if (k == P2C) begin : g_p2c
        // dividend: (np + wb * 2^31) / 2^32, divided by wb later
        always_comb begin
          logic [63:0] n;
          st_nxt[k] = st_r[k-1];
          n = {2'b0, st_r[k-1].np} + {17'd0, wb, 31'd0};
          st_nxt[k].dd   = n[63:32];
          st_nxt[k].rem  = '0;
          st_nxt[k].quot = '0;
        end
      end else if (k == P3) begin : g_p3
        // course angle, wrapped to +-180 and folded into +-90
        always_comb begin
          logic signed [26:0] phi;
          st_nxt[k] = st_r[k-1];
          phi = {{2{st_r[k-1].hd[16]}}, st_r[k-1].hd, 8'd0} + st_r[k-1].z;
          if (phi >= bmt_pkg::DEG180)       phi = phi - bmt_pkg::DEG360;
          else if (phi < -bmt_pkg::DEG180)  phi = phi + bmt_pkg::DEG360;
          st_nxt[k].neg = 1'b0;
          if (phi > bmt_pkg::DEG90) begin
            phi = phi - bmt_pkg::DEG180;
            st_nxt[k].neg = 1'b1;
          end else if (phi < -bmt_pkg::DEG90) begin
            phi = phi + bmt_pkg::DEG180;
            st_nxt[k].neg = 1'b1;
          end
          st_nxt[k].z = phi;
          st_nxt[k].x = bmt_pkg::CORDIC_K;
          st_nxt[k].y = '0;
        end
      end else if (k == P4) begin : g_p4
        // velocity magnitudes and signs
        always_comb begin
          logic [33:0] ax;
          logic [33:0] ay;
          logic [16:0] as;
          logic        cn;
          logic        sn;
          st_nxt[k] = st_r[k-1];
          ax = st_r[k-1].x[33] ? 34'(-st_r[k-1].x) : 34'(st_r[k-1].x);
          ay = st_r[k-1].y[33] ? 34'(-st_r[k-1].y) : 34'(st_r[k-1].y);
          as = st_r[k-1].spd[15] ? 17'(-{st_r[k-1].spd[15], st_r[k-1].spd})
                                 : {1'b0, st_r[k-1].spd};
          cn = st_r[k-1].neg ? (!st_r[k-1].x[33] && st_r[k-1].x != '0) : st_r[k-1].x[33];
          sn = st_r[k-1].neg ? (!st_r[k-1].y[33] && st_r[k-1].y != '0) : st_r[k-1].y[33];
          st_nxt[k].px    = 50'(as * ax[32:0]);
          st_nxt[k].py    = 50'(as * ay[32:0]);
          st_nxt[k].xneg  = st_r[k-1].spd[15] != cn;
          st_nxt[k].vyneg = st_r[k-1].spd[15] != sn;
        end
      end else if (k == P5) begin : g_p5
        // round, clamp, restore sign
        always_comb begin
          logic [27:0] mx;
          logic [27:0] my;
          st_nxt[k] = st_r[k-1];
          mx = 28'((st_r[k-1].px + 50'd2097152) >> 22);
          my = 28'((st_r[k-1].py + 50'd2097152) >> 22);
          if (mx > bmt_pkg::VEL_MAX) mx = bmt_pkg::VEL_MAX;
          if (my > bmt_pkg::VEL_MAX) my = bmt_pkg::VEL_MAX;
          st_nxt[k].vx = st_r[k-1].xneg  ? 25'(-$signed({1'b0, mx[24:0]})) : $signed(mx[24:0]);
          st_nxt[k].vy = st_r[k-1].vyneg ? 25'(-$signed({1'b0, my[24:0]})) : $signed(my[24:0]);
        end
      end else if (k >= DV && k < P6) begin : g_div
        // one restoring division step
        always_comb begin
          logic [16:0] r2;
          logic        qb;
          st_nxt[k] = st_r[k-1];
          r2 = {st_r[k-1].rem[15:0], st_r[k-1].dd[31]};
          qb = r2 >= {1'b0, wb};
          st_nxt[k].rem  = qb ? 17'(r2 - {1'b0, wb}) : r2;
          st_nxt[k].dd   = {st_r[k-1].dd[30:0], 1'b0};
          st_nxt[k].quot = {st_r[k-1].quot[30:0], qb};
        end
      end else begin : g_fwd
        always_comb st_nxt[k] = st_r[k-1];
      end
    end
  endgenerate

  // stage registers and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NST; j++) st_r[j] <= st_nxt[j];
    end
  end

  // yaw saturation and sign on the last stage
  always_comb begin
    logic [23:0] q;
    last_res.vx  = st_r[P6-1].vx;
    last_res.vy  = st_r[P6-1].vy;
    last_res.sat = st_r[P6-1].quot > bmt_pkg::YAW_MAX;
    q = last_res.sat ? bmt_pkg::YAW_MAX[23:0] : st_r[P6-1].quot[23:0];
    last_res.yaw = st_r[P6-1].yneg ? 24'(-$signed(q)) : $signed(q);
  end

  bmt_pkg::res_t out_r;
  logic          out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= vld_r[P6-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= last_res;
  end

  // skid register holds the output transaction when the pipeline moves under a stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (m_axis_tready) skid_v_r <= 1'b0;
    end else if (out_v_r && !m_axis_tready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) skid_r <= out_r;
  end

  // output channel
  bmt_pkg::res_t res;
  assign res           = skid_v_r ? skid_r : out_r;
  assign m_axis_tvalid = skid_v_r || out_v_r;
  assign m_axis_tdata  = {6'd0, res.yaw, res.vy, res.vx};
  assign m_axis_tuser  = res.sat;

endmodule

// ----- tb/sv/tb_bicycle_model_twist.sv -----
`timescale 1ns / 1ps

// expected twist results, oldest first
class twist_scoreboard;
  logic [24:0] vx_q[$];
  logic [24:0] vy_q[$];
  logic [23:0] yaw_q[$];
  logic        sat_q[$];
  int          errors;

  function new();
    errors = 0;
  endfunction

  function void note_input(logic [24:0] vx, logic [24:0] vy, logic [23:0] yaw, logic sat);
    vx_q.push_back(vx);
    vy_q.push_back(vy);
    yaw_q.push_back(yaw);
    sat_q.push_back(sat);
  endfunction

  function void check_result(logic [24:0] vx, logic [24:0] vy, logic [23:0] yaw, logic sat);
    logic [24:0] ex;
    logic [24:0] ey;
    logic [23:0] ew;
    logic        es;
    if (vx_q.size() == 0) begin
      $display("%0t unexpected result vx=%h vy=%h yaw=%h sat=%b", $time, vx, vy, yaw, sat);
      errors++;
      return;
    end
    ex = vx_q.pop_front();
    ey = vy_q.pop_front();
    ew = yaw_q.pop_front();
    es = sat_q.pop_front();
    if (vx !== ex) begin
      $display("%0t vel_x expected %h actual %h", $time, ex, vx);
      errors++;
    end
    if (vy !== ey) begin
      $display("%0t vel_y expected %h actual %h", $time, ey, vy);
      errors++;
    end
    if (yaw !== ew) begin
      $display("%0t turn_rate expected %h actual %h", $time, ew, yaw);
      errors++;
    end
    if (sat !== es) begin
      $display("%0t yaw_saturated expected %b actual %b", $time, es, sat);
      errors++;
    end
  endfunction

  function int pending();
    return vx_q.size();
  endfunction
endclass

module tb_bicycle_model_twist;

  localparam int STAGES  = 16;
  localparam int LATENCY = 3 * STAGES + 41;
  localparam int NUM_RANDOM = 1950;
  localparam int WATCHDOG = 20000;

  logic        clk;
  logic        rst_n;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  twist_scoreboard sb;
  bit [15:0] axle_ratio;
  bit [15:0] wheelbase;
  int        idle_cnt;
  bit        stim_done;
  int        sink_wait;

  bicycle_model_twist #(.CORDIC_STAGES(STAGES)) DUT (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // arctangent table in 1/65536 degree
  function automatic longint atan_entry(int i);
    longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117302, 58666, 29335,
                        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4,
                        2, 1, 0};
    return tab[i];
  endfunction

  // rotation: angle within +-90 degrees to q30 cosine and sine
  task automatic rotate_angle(input longint ang, output longint c, output longint s);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = 652032874;
    y = 0;
    z = ang;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    c = x;
    s = y;
  endtask

  // vectoring: atan(y / x) in 1/65536 degree
  function automatic longint vector_angle(longint x0, longint y0);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = x0;
    y = y0;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_entry(i);
      end else begin
        x -= dx; y += dy; z -= atan_entry(i);
      end
    end
    return z;
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [24:0] scale_velocity(longint spd, longint c);
    longint m;
    m = (abs64(spd) * abs64(c) + (longint'(1) << 21)) >>> 22;
    if (m > 8388608) m = 8388608;
    return ((spd < 0) != (c < 0)) ? 25'(-m) : 25'(m);
  endfunction

  // expected twist for one input transaction
  task automatic predict_twist(input logic [16:0] hd, input logic [15:0] st,
                               input logic [15:0] sp);
    longint heading_v;
    longint steer_v;
    longint speed_v;
    longint cs;
    longint ss;
    longint cp;
    longint sn;
    longint beta;
    longint phi;
    longint wb;
    longint m;
    longint quo;
    logic   neg;
    logic   sat;
    logic [127:0] num;
    heading_v = longint'($signed(hd));
    steer_v = longint'($signed(st));
    speed_v = longint'($signed(sp));
    neg = 1'b0;
    sat = 1'b0;
    if (steer_v > 21760) steer_v = 21760;
    if (steer_v < -21760) steer_v = -21760;
    rotate_angle(steer_v * 256, cs, ss);
    // c division truncates toward zero
    beta = vector_angle(cs, (ss * longint'(axle_ratio)) / 65536);
    phi = heading_v * 256 + beta;
    if (phi >= 11796480) phi -= 23592960;
    if (phi < -11796480) phi += 23592960;
    if (phi > 5898240) begin
      phi -= 11796480; neg = 1'b1;
    end else if (phi < -5898240) begin
      phi += 11796480; neg = 1'b1;
    end
    rotate_angle(phi, cp, sn);
    if (neg) begin
      cp = -cp; sn = -sn;
    end
    wb = (wheelbase == 0) ? 1 : longint'(wheelbase);
    m = (abs64(speed_v) * abs64(ss) + 8192) >>> 14;
    num = 128'(m) * 128'd961263669 + (128'(wb) << 31);
    quo = longint'(num / (128'(wb) << 32));
    if (quo > 8388607) begin
      quo = 8388607; sat = 1'b1;
    end
    if ((speed_v < 0) != (ss < 0)) quo = -quo;
    sb.note_input(scale_velocity(speed_v, cp), scale_velocity(speed_v, sn), 24'(quo), sat);
  endtask

  // register write while the pipeline is empty
  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == bmt_pkg::CFG_AXLE_RATIO) axle_ratio = val;
    else wheelbase = val;
    @(posedge clk);
  endtask

  // one input transaction with a random gap ahead of it
  task automatic send_item(input logic [16:0] hd, input logic [15:0] st, input logic [15:0] sp,
                           input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, sp, st, hd};
    do @(posedge clk); while (!s_axis_tready);
    predict_twist(hd, st, sp);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    logic [16:0] hd;
    logic [15:0] st;
    logic [15:0] sp;
    bit gaps;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) gaps = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: hd = 17'($urandom());
        default: hd = 17'($signed(32'($urandom_range(0, 92160)) - 46080));
      endcase
      case ($urandom_range(0, 3))
        0: st = 16'($urandom());
        default: st = 16'($signed(32'($urandom_range(0, 43520)) - 21760));
      endcase
      sp = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom());
      send_item(hd, st, sp, gaps);
    end
    drain();
  endtask

  // result sink with random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      m_axis_tready <= 1'b0;
      sink_wait <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata[24:0], m_axis_tdata[49:25], m_axis_tdata[73:50],
                        m_axis_tuser);
      if (sink_wait > 0) begin
        sink_wait <= sink_wait - 1;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready || !m_axis_tready) begin
        if (stim_done || $urandom_range(0, 3) == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          sink_wait <= $urandom_range(0, 5);
          m_axis_tready <= 1'b0;
        end
      end
    end
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    stim_done = 1'b0;
    idle_cnt = 0;
    axle_ratio = 16'd32768;
    wheelbase = 16'd300;
    rst_n = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = bmt_pkg::CFG_AXLE_RATIO;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, steering saturation, heading wrap, reset settings
    send_item(17'h00000, 16'h0000, 16'h0000, 1'b0);
    send_item(17'(46080), 16'(21760), 16'(32767), 1'b0);
    send_item(17'(-46080), 16'(-21760), 16'h8000, 1'b0);
    send_item(17'h0FFFF, 16'h7FFF, 16'h7FFF, 1'b1);
    send_item(17'h10000, 16'h8000, 16'h8000, 1'b1);
    send_item(17'h1FFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_item(17'(23040), 16'(100), 16'(1000), 1'b0);
    send_item(17'(-23041), 16'(-100), 16'(-1000), 1'b0);
    send_item(17'(45000), 16'(21000), 16'(-32768), 1'b0);
    send_item(17'(-45000), 16'(-21000), 16'(5), 1'b1);
    drain();

    // extremes of the registers: yaw saturation with tiny wheelbase, zero wheelbase
    write_reg(bmt_pkg::CFG_WHEELBASE, 16'd0);
    write_reg(bmt_pkg::CFG_AXLE_RATIO, 16'hFFFF);
    send_item(17'(1000), 16'(21760), 16'(32767), 1'b0);
    send_item(17'(-1000), 16'(-21760), 16'(32767), 1'b0);
    send_item(17'(46080), 16'(256), 16'(-7), 1'b0);
    send_item(17'(0), 16'(0), 16'(-32768), 1'b0);
    drain();
    write_reg(bmt_pkg::CFG_AXLE_RATIO, 16'd0);
    write_reg(bmt_pkg::CFG_WHEELBASE, 16'd65535);
    send_item(17'(1000), 16'(21760), 16'(32767), 1'b0);
    send_item(17'(-46080), 16'(-21760), 16'(-32768), 1'b0);
    drain();

    // random phases across several settings
    write_reg(bmt_pkg::CFG_AXLE_RATIO, 16'd32768);
    write_reg(bmt_pkg::CFG_WHEELBASE, 16'd300);
    random_phase(NUM_RANDOM / 5);
    write_reg(bmt_pkg::CFG_AXLE_RATIO, 16'hFFFF);
    write_reg(bmt_pkg::CFG_WHEELBASE, 16'd1);
    random_phase(NUM_RANDOM / 5);
    write_reg(bmt_pkg::CFG_AXLE_RATIO, 16'd0);
    write_reg(bmt_pkg::CFG_WHEELBASE, 16'd65535);
    random_phase(NUM_RANDOM / 5);
    for (int k = 0; k < 2; k++) begin
      write_reg(bmt_pkg::CFG_AXLE_RATIO, 16'($urandom()));
      write_reg(bmt_pkg::CFG_WHEELBASE, 16'($urandom_range(0, 2000)));
      random_phase(NUM_RANDOM / 5);
    end

    stim_done = 1'b1;
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
